// File: sv/first_substring_match_finder_top_defines.svh
// assertion helpers used by the asserting top-level file
`ifndef FIRST_SUBSTRING_MATCH_FINDER_TOP_DEFINES_SVH
`define FIRST_SUBSTRING_MATCH_FINDER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FSMF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define FSMF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/fsmf_pkg.sv
package fsmf_pkg;

	localparam int BYTE_W      = 8;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_IDX_W   = 2;
	localparam int LEN_REG_W   = 5;
	localparam int OUT_W       = 16;
	localparam int LOW_BYTES   = CFG_DATA_W / BYTE_W;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 2'd2;

	localparam logic [LEN_REG_W-1:0] PATTERN_LEN_RESET = 5'd1;

	// per-cycle controls for the row of match cells
	typedef struct packed {
		logic advance;
		logic clear;
	} cell_ctrl_t;

endpackage

// File: sv/fsmf_cell.sv
module fsmf_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  fsmf_pkg::cell_ctrl_t           ctrl,
	input  logic [fsmf_pkg::BYTE_W-1:0]    text_byte,
	input  logic [fsmf_pkg::BYTE_W-1:0]    pattern_byte,
	input  logic                           prev_match,
	output logic                           match_d,
	output logic                           match_q
);

	// prefix ending here matches if the shorter prefix matched one byte ago
	assign match_d = prev_match && (text_byte == pattern_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctrl.advance) begin
			match_q <= ctrl.clear ? 1'b0 : match_d;
		end
	end

endmodule

// File: sv/first_substring_match_finder_top.sv
// Streaming first-occurrence substring search.
// Input channel (in_valid/in_ready): one text byte per transaction, end_of_text
// on the last byte of a text. Output channel (out_valid/out_ready): one result
// transaction per text: found, before_length (bytes ahead of the first
// occurrence, or the text length) and text_length, both saturating at 65535.
// Config port: cfg_write with cfg_index 0/1 loads pattern bytes 0-7 / 8-15,
// index 2 loads the pattern length; write only while no text is in flight.
// Throughput: one byte per cycle unless stalled. Each of the MAX_PATTERN_BYTES
// cells in the row tracks one pattern prefix and updates once per accepted byte.
// Latency: the result is registered, out_valid rises the cycle after the last
// byte is accepted. State clears on that same edge, so the next text may start
// in the following cycle.
// Reset: pattern bytes zero, length one, no text in flight, no result held.
// Stall: while a result waits with out_ready low, in_ready is low and no byte
// is taken; in a cycle where out_ready is high, bytes keep flowing.
`include "first_substring_match_finder_top_defines.svh"

module first_substring_match_finder_top #(
	parameter int MAX_PATTERN_BYTES = 16,
	parameter int POSITION_BITS     = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [fsmf_pkg::BYTE_W-1:0]       text_byte,
	input  logic                              end_of_text,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              found,
	output logic [fsmf_pkg::OUT_W-1:0]        before_length,
	output logic [fsmf_pkg::OUT_W-1:0]        text_length,
	input  logic                              cfg_write,
	input  logic [fsmf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fsmf_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
	localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
	localparam int BW    = fsmf_pkg::BYTE_W;
	localparam int LB    = fsmf_pkg::LOW_BYTES;

	logic [fsmf_pkg::CFG_DATA_W-1:0] pat_lo_q;
	logic [fsmf_pkg::CFG_DATA_W-1:0] pat_hi_q;
	logic [fsmf_pkg::LEN_REG_W-1:0]  pat_len_q;

	logic [POSITION_BITS-1:0] pos_q;
	logic                     seen_q;
	logic [POSITION_BITS-1:0] off_q;

	logic                     out_valid_q;
	logic                     found_q;
	logic [fsmf_pkg::OUT_W-1:0] before_q;
	logic [fsmf_pkg::OUT_W-1:0] length_q;

	logic                     accept;
	fsmf_pkg::cell_ctrl_t     ctrl;

	logic [fsmf_pkg::LEN_REG_W-1:0] len_nz;
	logic [LEN_W-1:0]         used_len;
	logic [LEN_W-1:0]         len_m1;
	logic [IDX_W-1:0]         sel;

	logic [MAX_PATTERN_BYTES-1:0] cell_match_d;
	logic [MAX_PATTERN_BYTES-1:0] cell_match_q;

	logic [POSITION_BITS-1:0] pos_next;
	logic                     hit;
	logic                     seen_next;
	logic [POSITION_BITS-1:0] off_next;
	logic [POSITION_BITS-1:0] before_full;
	logic [fsmf_pkg::OUT_W-1:0] before_clip;
	logic [fsmf_pkg::OUT_W-1:0] length_clip;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q  <= '0;
			pat_hi_q  <= '0;
			pat_len_q <= fsmf_pkg::PATTERN_LEN_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				fsmf_pkg::REG_PATTERN_LOW:  pat_lo_q  <= cfg_data;
				fsmf_pkg::REG_PATTERN_HIGH: pat_hi_q  <= cfg_data;
				fsmf_pkg::REG_PATTERN_LEN:  pat_len_q <= cfg_data[fsmf_pkg::LEN_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// length zero acts as one, lengths above the cell count clamp to it
	always_comb begin
		len_nz = (pat_len_q == '0) ? fsmf_pkg::PATTERN_LEN_RESET : pat_len_q;
		if (int'(len_nz) > MAX_PATTERN_BYTES) begin
			used_len = LEN_W'(MAX_PATTERN_BYTES);
		end else begin
			used_len = LEN_W'(len_nz);
		end
		len_m1 = used_len - LEN_W'(1);
		sel    = IDX_W'(len_m1);
	end

	assign accept     = in_valid && in_ready;
	assign ctrl.advance = accept;
	assign ctrl.clear   = end_of_text;

	// row of prefix cells, cell k matches pattern bytes 0..k ending at the newest byte
	for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
		logic [BW-1:0] pb;
		logic          prev;

		if (k < LB) begin : g_lo
			assign pb = pat_lo_q[BW*k +: BW];
		end else if (k < 2 * LB) begin : g_hi
			assign pb = pat_hi_q[BW*(k-LB) +: BW];
		end else begin : g_zero
			assign pb = '0;
		end

		if (k == 0) begin : g_head
			assign prev = 1'b1;
		end else begin : g_link
			assign prev = cell_match_q[k-1];
		end

		fsmf_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl),
			.text_byte    (text_byte),
			.pattern_byte (pb),
			.prev_match   (prev),
			.match_d      (cell_match_d[k]),
			.match_q      (cell_match_q[k])
		);
	end

	always_comb begin
		pos_next  = (&pos_q) ? pos_q : pos_q + POSITION_BITS'(1);
		hit       = !seen_q && (pos_next >= POSITION_BITS'(used_len)) && cell_match_d[sel];
		seen_next = seen_q || hit;
		off_next  = hit ? (pos_next - POSITION_BITS'(used_len)) : off_q;
		before_full = seen_next ? off_next : pos_next;
	end

	if (POSITION_BITS > fsmf_pkg::OUT_W) begin : g_clip
		localparam logic [fsmf_pkg::OUT_W-1:0] OUT_MAX = '1;
		assign before_clip = (before_full > POSITION_BITS'(OUT_MAX)) ? OUT_MAX
			: before_full[fsmf_pkg::OUT_W-1:0];
		assign length_clip = (pos_next > POSITION_BITS'(OUT_MAX)) ? OUT_MAX
			: pos_next[fsmf_pkg::OUT_W-1:0];
	end else begin : g_ext
		assign before_clip = fsmf_pkg::OUT_W'(before_full);
		assign length_clip = fsmf_pkg::OUT_W'(pos_next);
	end

	// per-text counters, cleared on the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			seen_q <= 1'b0;
			off_q  <= '0;
		end else if (accept) begin
			if (end_of_text) begin
				pos_q  <= '0;
				seen_q <= 1'b0;
				off_q  <= '0;
			end else begin
				pos_q  <= pos_next;
				seen_q <= seen_next;
				off_q  <= off_next;
			end
		end
	end

	// result register
	assign in_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && end_of_text) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && end_of_text) begin
			found_q  <= seen_next;
			before_q <= before_clip;
			length_q <= length_clip;
		end
	end

	assign out_valid     = out_valid_q;
	assign found         = found_q;
	assign before_length = before_q;
	assign text_length   = length_q;

	`FSMF_ASSERT_NEXT(a_last_gives_result, in_valid && in_ready && end_of_text, out_valid,
		"last byte accepted but no result presented")
	`FSMF_ASSERT_NEXT(a_last_clears_text, in_valid && in_ready && end_of_text,
		pos_q == '0 && !seen_q, "text state not cleared after last byte")
	`FSMF_ASSERT_NOW(a_offset_in_range, seen_q, off_q <= pos_q,
		"match offset beyond byte position")
	`FSMF_ASSERT_NOW(a_before_le_length, out_valid, before_length <= text_length,
		"before_length exceeds text_length")

endmodule
